>>> hw/rtl/ibwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibwt_pkg;

  localparam int SYMBOLS       = 256;
  localparam int SYM_W         = 8;
  localparam int PIDX_W        = 12;
  localparam int DEF_BLOCK_LEN = 4096;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_PULL = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DATA   = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN,
    S_PREFIX,
    S_LINK,
    S_CLEAR,
    S_PULL_LINK,
    S_PULL_BYTE,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/inverse_bwt_block_decoder.sv
// Inverse Burrows-Wheeler block decoder.
// Input stream (s_*): one beat per item. s_tuser selects load (0) or pull (1).
// A load beat carries one transformed byte; the beat with s_tlast closes the
// block and carries the primary index. Output stream (m_*): one beat per pull,
// with the decoded byte, tlast on the final byte and the status in tuser.
// Loads are taken one per cycle while idle; a symbol-count memory is updated by a
// read-modify-write stage with forwarding from the previous write.
// Closing a block runs a drain step, a prefix pass over the count memory,
// a link pass over the block store and a clear of the count memory, or only
// the drain step and the clear when the primary index is out of range.
// A pull passes link read, store read, result and output register on the way
// to its output beat; a status-only answer goes straight to the output
// register. s_tready is low while a block is being closed or a pull is in flight.
// Reset starts a clear of the count memory; no beat is taken then.
// A stalled output beat holds in its register while loads carry on; the next
// pull waits until that beat has been taken.

`timescale 1ns / 1ps
`default_nettype none

module inverse_bwt_block_decoder #(
  parameter int BLOCK_LEN = ibwt_pkg::DEF_BLOCK_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [19:8] primary_index, [23:20] zero
  input  wire logic        s_tlast,
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast,
  output logic [1:0]       m_tuser    // [1:0] status
);
  import ibwt_pkg::*;

  localparam int AW = $clog2(BLOCK_LEN);
  localparam int CW = $clog2(BLOCK_LEN + 1);
  localparam int XW = (CW > PIDX_W) ? CW : PIDX_W;
  localparam logic [CW-1:0] BLK_MAX = CW'(BLOCK_LEN);

  state_t state, state_next;

  // memories
  logic [SYM_W-1:0] store_mem [BLOCK_LEN];
  logic [AW-1:0]    link_mem  [BLOCK_LEN];
  logic [CW-1:0]    cnt_mem   [SYMBOLS];
  logic [SYM_W-1:0] store_rd;
  logic [AW-1:0]    link_rd;
  logic [CW-1:0]    cnt_rd;

  // block state
  logic [CW-1:0] fill;
  logic [CW-1:0] remaining;
  logic [CW-1:0] blk_len;
  logic [AW-1:0] chain_pos;
  logic          index_error;

  // count update stage
  logic             s1_valid;
  logic             s1_link;
  logic [SYM_W-1:0] s1_sym;
  logic [AW-1:0]    s1_pos;
  logic             last_wr_valid;
  logic [SYM_W-1:0] last_wr_sym;
  logic [CW-1:0]    last_wr_val;
  logic [CW-1:0]    s1_base;
  logic [CW-1:0]    s1_inc;

  // prefix, link and clear passes
  logic [SYM_W:0]   pf_ptr;
  logic             pf_valid;
  logic [SYM_W-1:0] pf_idx;
  logic [CW-1:0]    pf_sum;
  logic [CW-1:0]    lp_ptr;
  logic             a_valid;
  logic [AW-1:0]    a_idx;
  logic [SYM_W-1:0] clr_ptr;

  // pending result
  logic [SYM_W-1:0] res_byte;
  logic             res_last;
  status_t          res_status;

  // strobes
  logic             load_acc, pull_acc, pull_go;
  logic             fill_ok, idx_bad, pf_issue, lp_issue, link_done, out_free;
  logic [CW-1:0]    n_blk;
  logic [SYM_W-1:0] in_byte;
  logic [PIDX_W-1:0] in_pidx;

  logic             cnt_we, cnt_re;
  logic [SYM_W-1:0] cnt_wa, cnt_ra;
  logic [CW-1:0]    cnt_wd;
  logic             st_re;
  logic [AW-1:0]    st_ra;

  assign in_byte  = s_tdata[7:0];
  assign in_pidx  = s_tdata[19:8];
  assign s_tready = (state == S_IDLE);
  assign load_acc = s_tvalid && s_tready && (s_tuser == KIND_LOAD);
  assign pull_acc = s_tvalid && s_tready && (s_tuser == KIND_PULL);
  assign pull_go  = pull_acc && !index_error && (remaining != '0);
  assign fill_ok  = (fill < BLK_MAX);
  assign n_blk    = fill_ok ? CW'(fill + CW'(1)) : fill;
  assign idx_bad  = (XW'(in_pidx) >= XW'(n_blk));
  assign pf_issue = (state == S_PREFIX) && (pf_ptr < (SYM_W + 1)'(SYMBOLS));
  assign lp_issue = (state == S_LINK) && (lp_ptr < blk_len);
  assign link_done = (lp_ptr == blk_len) && !a_valid && !s1_valid;
  assign out_free = !m_tvalid || m_tready;

  // forward the count written in the previous cycle
  assign s1_base = (last_wr_valid && (last_wr_sym == s1_sym)) ? last_wr_val : cnt_rd;
  assign s1_inc  = CW'(s1_base + CW'(1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (load_acc && s_tlast) begin
          state_next = S_DRAIN;
        end else if (pull_go) begin
          state_next = S_PULL_LINK;
        end else if (pull_acc) begin
          state_next = S_EMIT;
        end
      end
      S_DRAIN:     state_next = index_error ? S_CLEAR : S_PREFIX;
      S_PREFIX:    if (pf_valid && (pf_idx == SYM_W'(SYMBOLS - 1))) state_next = S_LINK;
      S_LINK:      if (link_done) state_next = S_CLEAR;
      S_CLEAR:     if (clr_ptr == SYM_W'(SYMBOLS - 1)) state_next = S_IDLE;
      S_PULL_LINK: state_next = S_PULL_BYTE;
      S_PULL_BYTE: state_next = S_EMIT;
      S_EMIT:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // count memory port selection
  always_comb begin
    cnt_we = s1_valid;
    cnt_wa = s1_sym;
    cnt_wd = s1_inc;
    cnt_re = 1'b0;
    cnt_ra = in_byte;
    case (state)
      S_IDLE: begin
        cnt_re = load_acc && fill_ok;
      end
      S_PREFIX: begin
        cnt_re = pf_issue;
        cnt_ra = pf_ptr[SYM_W-1:0];
        cnt_we = pf_valid;
        cnt_wa = pf_idx;
        cnt_wd = pf_sum;
      end
      S_LINK: begin
        cnt_re = a_valid;
        cnt_ra = store_rd;
      end
      S_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_ptr;
        cnt_wd = '0;
      end
      default: begin
        cnt_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_re = 1'b0;
    st_ra = lp_ptr[AW-1:0];
    if (lp_issue) begin
      st_re = 1'b1;
    end else if (state == S_PULL_LINK) begin
      st_re = 1'b1;
      st_ra = link_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (load_acc && fill_ok) store_mem[fill[AW-1:0]] <= in_byte;
    if (st_re) store_rd <= store_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_link) link_mem[s1_base[AW-1:0]] <= s1_pos;
    if (pull_go) link_rd <= link_mem[chain_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      remaining     <= '0;
      index_error   <= 1'b0;
      chain_pos     <= '0;
      s1_valid      <= 1'b0;
      s1_link       <= 1'b0;
      last_wr_valid <= 1'b0;
      pf_ptr        <= '0;
      pf_valid      <= 1'b0;
      lp_ptr        <= '0;
      a_valid       <= 1'b0;
      clr_ptr       <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      last_wr_valid <= s1_valid;
      last_wr_sym   <= s1_sym;
      last_wr_val   <= s1_inc;
      s1_valid      <= 1'b0;
      s1_link       <= 1'b0;

      if (m_tready) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (load_acc) begin
            if (fill_ok) begin
              s1_valid <= 1'b1;
              s1_sym   <= in_byte;
            end
            fill <= s_tlast ? '0 : n_blk;
            if (s_tlast) begin
              index_error <= idx_bad;
              remaining   <= idx_bad ? '0 : n_blk;
              if (!idx_bad) begin
                chain_pos <= AW'(in_pidx);
                blk_len   <= n_blk;
              end
            end else if (fill == '0) begin
              remaining   <= '0;
              index_error <= 1'b0;
            end
          end else if (pull_acc) begin
            res_byte <= '0;
            res_last <= 1'b0;
            res_status <= index_error ? ST_BAD_INDEX : ST_NO_DATA;
          end
        end
        S_DRAIN: begin
          pf_ptr   <= '0;
          pf_valid <= 1'b0;
          pf_sum   <= '0;
          clr_ptr  <= '0;
        end
        S_PREFIX: begin
          pf_valid <= pf_issue;
          pf_idx   <= pf_ptr[SYM_W-1:0];
          if (pf_issue) pf_ptr <= pf_ptr + (SYM_W + 1)'(1);
          if (pf_valid) pf_sum <= CW'(pf_sum + cnt_rd);
          lp_ptr  <= '0;
          a_valid <= 1'b0;
        end
        S_LINK: begin
          a_valid <= lp_issue;
          a_idx   <= lp_ptr[AW-1:0];
          if (lp_issue) lp_ptr <= CW'(lp_ptr + CW'(1));
          // count read for this byte was issued this cycle; update next
          if (a_valid) begin
            s1_valid <= 1'b1;
            s1_link  <= 1'b1;
            s1_sym   <= store_rd;
            s1_pos   <= a_idx;
          end
          clr_ptr <= '0;
        end
        S_CLEAR: begin
          clr_ptr <= clr_ptr + SYM_W'(1);
        end
        S_PULL_LINK: begin
          chain_pos <= link_rd;
          remaining <= CW'(remaining - CW'(1));
        end
        S_PULL_BYTE: begin
          res_byte   <= store_rd;
          res_last   <= (remaining == '0);
          res_status <= ST_OK;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_byte;
            m_tlast  <= res_last;
            m_tuser  <= res_status;
          end
        end
        default: begin
          s1_valid <= 1'b0;
        end
      endcase
    end
  end

  // count memory has a single write port: no update may overlap the prefix or clear pass
  a_cnt_port_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREFIX || state == S_CLEAR) |-> !s1_valid)
    else $error("count update overlaps prefix or clear pass");

  a_link_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> (lp_ptr <= blk_len))
    else $error("link pass ran past the block length");

  a_close_drain: assert property (@(posedge clk) disable iff (rst)
    (load_acc && s_tlast) |=> (state == S_DRAIN) && (fill == '0))
    else $error("last load did not close the block");

  a_pull_ok_bytes: assert property (@(posedge clk) disable iff (rst)
    pull_go |=> (state == S_PULL_LINK) && (remaining != '0))
    else $error("pull started with no decoded bytes left");

endmodule

`default_nettype wire
